/* rtl/sm4_block_cipher_top_assert.svh */
// Assertion macros for the SM4 core.
// Needs clk and rst_n in the scope of use; no other dependencies.
`ifndef SM4_BLOCK_CIPHER_TOP_ASSERT_SVH
`define SM4_BLOCK_CIPHER_TOP_ASSERT_SVH

// same-cycle implication
`define SM4_ASSERT_SAME(LBL, ANT, CON) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |-> (CON)) \
    else $error("sm4 check failed");

// next-cycle implication
`define SM4_ASSERT_NEXT(LBL, ANT, CON) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |=> (CON)) \
    else $error("sm4 check failed");

`endif

/* rtl/sm4_pkg.sv */
// SM4 package: word type, S-box, FK constants, CK generation and linear maps.
// No dependencies; used by sm4_block_cipher_top.
package sm4_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned ROUNDS        = 32;
  localparam int unsigned RND_W         = $clog2(ROUNDS);
  localparam int unsigned NUM_KEY_WORDS = 4;
  localparam int unsigned KEY_IDX_W     = $clog2(NUM_KEY_WORDS);
  localparam int unsigned CFG_IDX_W     = 3;

  localparam word_t FK [NUM_KEY_WORDS] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t rol(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic word_t sbox_word(word_t v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // round transform L
  function automatic word_t lin_enc(word_t b);
    return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
  endfunction

  // key schedule transform L'
  function automatic word_t lin_key(word_t b);
    return b ^ rol(b, 13) ^ rol(b, 23);
  endfunction

  // CK byte j of word i = (4i + j) * 7 mod 256
  function automatic word_t ck_word(logic [RND_W-1:0] i);
    logic [7:0] base;
    logic [7:0] m;
    word_t      w;
    base = 8'({i, 2'b00});
    w    = '0;
    for (int j = 0; j < 4; j++) begin
      m = base + 8'(j);
      w = {w[23:0], 8'((m << 3) - m)};
    end
    return w;
  endfunction

endpackage

/* rtl/sm4_block_cipher_top.sv */
// SM4 core: 32 round keys in a 32x32 synchronous RAM, one round per cycle.
// When the keys are stale (after reset or a key write), key expansion into the RAM runs first.
// The input stalls (in_stall) from request accept until the result is loaded into the output
// registers; the round loop reads one round key per cycle from the single RAM read port.
// Reset: synchronous active-low rst_n; key registers cleared, expansion pending,
// round key RAM not cleared (always rewritten before first use).
`include "sm4_block_cipher_top_assert.svh"

module sm4_block_cipher_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  sm4_pkg::word_t                cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  sm4_pkg::word_t                in_block_word0,
  input  sm4_pkg::word_t                in_block_word1,
  input  sm4_pkg::word_t                in_block_word2,
  input  sm4_pkg::word_t                in_block_word3,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sm4_pkg::word_t                out_word0,
  output sm4_pkg::word_t                out_word1,
  output sm4_pkg::word_t                out_word2,
  output sm4_pkg::word_t                out_word3
);

  localparam int unsigned RW = sm4_pkg::RND_W;
  localparam logic [RW-1:0] LAST = RW'(sm4_pkg::ROUNDS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_PRIME  = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [RW-1:0]  cnt_r, cnt_nxt;
  logic           keys_stale_r;
  logic           out_valid_r;
  logic           dec_r;
  sm4_pkg::word_t key_r [sm4_pkg::NUM_KEY_WORDS];
  sm4_pkg::word_t k_r [4];
  sm4_pkg::word_t x_r [4];
  sm4_pkg::word_t out_word0_r, out_word1_r, out_word2_r, out_word3_r;

  sm4_pkg::word_t rk_mem [sm4_pkg::ROUNDS];
  sm4_pkg::word_t rk_q;
  logic           rk_re;
  logic [RW-1:0]  fetch_idx;
  logic [RW-1:0]  rk_raddr;

  logic           in_req;
  logic           key_we;
  logic           out_free;
  logic           out_load;
  logic           expanding;
  logic           rounding;
  sm4_pkg::word_t sbox_in;
  sm4_pkg::word_t sbox_out;
  sm4_pkg::word_t nk;
  sm4_pkg::word_t nx;

  assign cfg_ready = 1'b1;
  assign key_we    = cfg_valid && cfg_ready
                     && (cfg_index < sm4_pkg::CFG_IDX_W'(sm4_pkg::NUM_KEY_WORDS));
  assign in_stall  = (state_r != ST_IDLE);
  assign in_req    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DONE) && out_free;
  assign expanding = (state_r == ST_EXPAND);
  assign rounding  = (state_r == ST_ROUND);

  // shared S-box layer for key schedule and rounds
  assign sbox_in  = expanding ? (k_r[1] ^ k_r[2] ^ k_r[3] ^ sm4_pkg::ck_word(cnt_r))
                              : (x_r[1] ^ x_r[2] ^ x_r[3] ^ rk_q);
  assign sbox_out = sm4_pkg::sbox_word(sbox_in);
  assign nk       = k_r[0] ^ sm4_pkg::lin_key(sbox_out);
  assign nx       = x_r[0] ^ sm4_pkg::lin_enc(sbox_out);

  // prefetch the key of the next round; decrypt walks the RAM backwards
  assign rk_re     = (state_r == ST_PRIME) || rounding;
  assign fetch_idx = rounding ? cnt_r + RW'(1) : '0;
  assign rk_raddr  = dec_r ? LAST - fetch_idx : fetch_idx;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          cnt_nxt   = '0;
          state_nxt = keys_stale_r ? ST_EXPAND : ST_PRIME;
        end
      end
      ST_EXPAND: begin
        cnt_nxt = cnt_r + RW'(1);
        if (cnt_r == LAST) state_nxt = ST_PRIME;
      end
      ST_PRIME: begin
        cnt_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + RW'(1);
        if (cnt_r == LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_stale_r <= 1'b1;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < sm4_pkg::NUM_KEY_WORDS; i++) key_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (key_we) begin
        key_r[cfg_index[sm4_pkg::KEY_IDX_W-1:0]] <= cfg_data;
        keys_stale_r <= 1'b1;
      end else if (expanding && cnt_r == LAST) begin
        keys_stale_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // round key RAM
  always_ff @(posedge clk) begin
    if (expanding) rk_mem[cnt_r] <= nk;
    if (rk_re) rk_q <= rk_mem[rk_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      dec_r  <= in_command;
      x_r[0] <= in_block_word0;
      x_r[1] <= in_block_word1;
      x_r[2] <= in_block_word2;
      x_r[3] <= in_block_word3;
      for (int i = 0; i < 4; i++) k_r[i] <= key_r[i] ^ sm4_pkg::FK[i];
    end else if (expanding) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= nk;
    end else if (rounding) begin
      x_r[0] <= x_r[1];
      x_r[1] <= x_r[2];
      x_r[2] <= x_r[3];
      x_r[3] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word0_r <= x_r[3];
      out_word1_r <= x_r[2];
      out_word2_r <= x_r[1];
      out_word3_r <= x_r[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word0 = out_word0_r;
  assign out_word1 = out_word1_r;
  assign out_word2 = out_word2_r;
  assign out_word3 = out_word3_r;

  `SM4_ASSERT_NEXT(a_stale_expands, in_req && keys_stale_r, state_r == ST_EXPAND)
  `SM4_ASSERT_NEXT(a_fresh_skips, in_req && !keys_stale_r, state_r == ST_PRIME)
  `SM4_ASSERT_NEXT(a_expand_clears, expanding && cnt_r == LAST && !key_we, !keys_stale_r)
  `SM4_ASSERT_NEXT(a_round_ends, rounding && cnt_r == LAST, state_r == ST_DONE)
  `SM4_ASSERT_NEXT(a_done_delivers, out_load, out_valid_r && state_r == ST_IDLE)

endmodule
